// File: rtl/mktd_pkg.sv
`default_nettype none

package mktd_pkg;

    localparam int STAMP_W  = 16;
    localparam int CFG_W    = 16;
    localparam int PERIOD_W = 17;
    localparam int ELAPSE_W = 18;
    localparam int CHAR_W   = 7;
    localparam int CODE_W   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [1:0] {
        ACT_RISE = 2'd0,
        ACT_FALL = 2'd1,
        ACT_POLL = 2'd2
    } action_t;

    localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_MIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAMP_GAP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD  = 3'd6;

    localparam logic [CFG_W-1:0]    RST_BOUNCE_WINDOW = 16'd1500;
    localparam logic [CFG_W-1:0]    RST_DOT_MIN       = 16'd1875;
    localparam logic [CFG_W-1:0]    RST_DASH_MIN      = 16'd12500;
    localparam logic [CFG_W-1:0]    RST_DASH_MAX      = 16'd25000;
    localparam logic [CFG_W-1:0]    RST_LAMP_GAP      = 16'd3125;
    localparam logic [CFG_W-1:0]    RST_LETTER_GAP    = 16'd25000;
    localparam logic [PERIOD_W-1:0] RST_TIMER_PERIOD  = 17'd65536;

    // ticks from then to now, adding one timer period when the counter wrapped
    function automatic logic [ELAPSE_W-1:0] elapsed(
        input logic [STAMP_W-1:0]  now,
        input logic [STAMP_W-1:0]  then_stamp,
        input logic [PERIOD_W-1:0] period
    );
        logic [ELAPSE_W-1:0] base;
        base = ELAPSE_W'(now);
        if (now < then_stamp)
        begin
            base = base + ELAPSE_W'(period);
        end
        return base - ELAPSE_W'(then_stamp);
    endfunction

    // marker bit then one bit per element, dash = 1, newest lowest
    function automatic logic [CHAR_W-1:0] morse_lookup(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            7'h05:   ch = 7'h41; // A
            7'h18:   ch = 7'h42;
            7'h1A:   ch = 7'h43;
            7'h0C:   ch = 7'h44;
            7'h02:   ch = 7'h45;
            7'h12:   ch = 7'h46;
            7'h0E:   ch = 7'h47;
            7'h10:   ch = 7'h48;
            7'h04:   ch = 7'h49;
            7'h17:   ch = 7'h4A;
            7'h0D:   ch = 7'h4B;
            7'h14:   ch = 7'h4C;
            7'h07:   ch = 7'h4D;
            7'h06:   ch = 7'h4E;
            7'h0F:   ch = 7'h4F;
            7'h16:   ch = 7'h50;
            7'h1D:   ch = 7'h51;
            7'h0A:   ch = 7'h52;
            7'h08:   ch = 7'h53;
            7'h03:   ch = 7'h54;
            7'h09:   ch = 7'h55;
            7'h11:   ch = 7'h56;
            7'h0B:   ch = 7'h57;
            7'h19:   ch = 7'h58;
            7'h1B:   ch = 7'h59;
            7'h1C:   ch = 7'h5A; // Z
            7'h2F:   ch = 7'h31; // 1
            7'h27:   ch = 7'h32;
            7'h23:   ch = 7'h33;
            7'h21:   ch = 7'h34;
            7'h20:   ch = 7'h35;
            7'h30:   ch = 7'h36;
            7'h38:   ch = 7'h37;
            7'h3C:   ch = 7'h38;
            7'h3E:   ch = 7'h39;
            7'h3F:   ch = 7'h30; // 0
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: rtl/morse_key_timing_decoder.sv
`default_nettype none

// Morse key decoder fed with timestamped key events (press edge, release
// edge, time poll) on the slave stream; every event gives one result on the
// master stream with the lamp levels and, when a letter gap closes a
// pattern, the decoded A-Z/0-9 character or an unknown flag. One event is
// taken per clock unless the master stream stalls; the transfer loads the
// input register, then the decode pass loads the result register. The user
// must write registers through the cfg channel only while idle, as the block
// has no check for this; they take effect on the next event.
module morse_key_timing_decoder
    import mktd_pkg::*;
#(
    parameter int MAX_ELEMENTS = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] stamp
    input  wire logic [1:0]            s_tuser,   // [1:0] action

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,   // [6:0] char_code, [7] press_lamp,
                                                  // [8] dot_lamp, [9] dash_lamp, rest 0
    output logic [1:0]                 m_tuser,   // [0] char_valid, [1] unknown_pattern

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PAT_W = MAX_ELEMENTS + 1;
    localparam int EXT_W = (PAT_W > CODE_W) ? PAT_W : CODE_W;

    logic [CFG_W-1:0]    bounce_window_reg, dot_min_reg, dash_min_reg, dash_max_reg;
    logic [CFG_W-1:0]    lamp_gap_reg, letter_gap_reg;
    logic [PERIOD_W-1:0] timer_period_reg;

    logic                in_valid_reg;
    logic [1:0]          in_action_reg;
    logic [STAMP_W-1:0]  in_stamp_reg;

    logic [STAMP_W-1:0]  press_start_reg, press_start_next;
    logic [STAMP_W-1:0]  release_time_reg, release_time_next;
    logic                release_seen_reg, release_seen_next;
    logic                expect_rise_reg, expect_rise_next;
    logic [PAT_W-1:0]    pattern_reg, pattern_next;
    logic                overflow_reg, overflow_next;
    logic                press_lamp_reg, press_lamp_next;
    logic                dot_lamp_reg, dot_lamp_next;
    logic                dash_lamp_reg, dash_lamp_next;

    logic                out_valid_reg;
    logic                out_char_valid_reg, out_char_valid_next;
    logic [CHAR_W-1:0]   out_char_code_reg, out_char_code_next;
    logic                out_unknown_reg, out_unknown_next;

    logic                accept_in;
    logic                advance;
    logic [ELAPSE_W-1:0] press_len;
    logic [ELAPSE_W-1:0] quiet_len;
    logic [STAMP_W-1:0]  stamp_diff;
    logic                bounce;
    logic                is_dot, is_dash;
    logic [EXT_W-1:0]    pattern_ext;
    logic [CHAR_W-1:0]   lookup_char;

    assign cfg_ready = 1'b1;
    assign accept_in = s_tvalid && s_tready;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounce_window_reg <= RST_BOUNCE_WINDOW;
            dot_min_reg       <= RST_DOT_MIN;
            dash_min_reg      <= RST_DASH_MIN;
            dash_max_reg      <= RST_DASH_MAX;
            lamp_gap_reg      <= RST_LAMP_GAP;
            letter_gap_reg    <= RST_LETTER_GAP;
            timer_period_reg  <= RST_TIMER_PERIOD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BOUNCE_WINDOW: bounce_window_reg <= cfg_data[CFG_W-1:0];
                REG_DOT_MIN:       dot_min_reg       <= cfg_data[CFG_W-1:0];
                REG_DASH_MIN:      dash_min_reg      <= cfg_data[CFG_W-1:0];
                REG_DASH_MAX:      dash_max_reg      <= cfg_data[CFG_W-1:0];
                REG_LAMP_GAP:      lamp_gap_reg      <= cfg_data[CFG_W-1:0];
                REG_LETTER_GAP:    letter_gap_reg    <= cfg_data[CFG_W-1:0];
                REG_TIMER_PERIOD:  timer_period_reg  <= cfg_data[PERIOD_W-1:0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_action_reg <= s_tuser;
            in_stamp_reg  <= s_tdata;
        end
    end

    assign press_len  = elapsed(in_stamp_reg, press_start_reg, timer_period_reg);
    assign quiet_len  = elapsed(in_stamp_reg, release_time_reg, timer_period_reg);
    assign stamp_diff = in_stamp_reg - release_time_reg;
    assign bounce     = release_seen_reg && (in_stamp_reg > release_time_reg)
                        && (stamp_diff < bounce_window_reg);
    assign is_dot     = (press_len >= ELAPSE_W'(dot_min_reg))
                        && (press_len < ELAPSE_W'(dash_min_reg));
    assign is_dash    = (press_len >= ELAPSE_W'(dash_min_reg))
                        && (press_len < ELAPSE_W'(dash_max_reg));

    assign pattern_ext = EXT_W'(pattern_reg);
    assign lookup_char = ((pattern_ext >> CODE_W) == '0)
                         ? morse_lookup(pattern_ext[CODE_W-1:0]) : '0;

    always_comb
    begin
        press_start_next    = press_start_reg;
        release_time_next   = release_time_reg;
        release_seen_next   = release_seen_reg;
        expect_rise_next    = expect_rise_reg;
        pattern_next        = pattern_reg;
        overflow_next       = overflow_reg;
        press_lamp_next     = press_lamp_reg;
        dot_lamp_next       = dot_lamp_reg;
        dash_lamp_next      = dash_lamp_reg;
        out_char_valid_next = 1'b0;
        out_char_code_next  = '0;
        out_unknown_next    = 1'b0;

        unique case (in_action_reg)
            ACT_RISE:
            begin
                if (expect_rise_reg && !bounce)
                begin
                    press_start_next  = in_stamp_reg;
                    release_seen_next = 1'b0;
                    press_lamp_next   = 1'b1;
                    expect_rise_next  = 1'b0;
                end
            end
            ACT_FALL:
            begin
                if (!expect_rise_reg)
                begin
                    if (is_dot || is_dash)
                    begin
                        if (pattern_reg[PAT_W-1])
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            pattern_next = {pattern_reg[PAT_W-2:0], is_dash};
                        end
                        release_time_next = in_stamp_reg;
                        release_seen_next = 1'b1;
                    end
                    if (is_dot)
                    begin
                        dot_lamp_next = 1'b1;
                    end
                    else if (is_dash)
                    begin
                        dash_lamp_next = 1'b1;
                    end
                    press_lamp_next  = 1'b0;
                    expect_rise_next = 1'b1;
                end
            end
            ACT_POLL:
            begin
                if (release_seen_reg)
                begin
                    if (quiet_len > ELAPSE_W'(lamp_gap_reg))
                    begin
                        dot_lamp_next  = 1'b0;
                        dash_lamp_next = 1'b0;
                    end
                    if (quiet_len >= ELAPSE_W'(letter_gap_reg))
                    begin
                        release_seen_next   = 1'b0;
                        out_char_valid_next = 1'b1;
                        out_char_code_next  = overflow_reg ? '0 : lookup_char;
                        out_unknown_next    = overflow_reg || (lookup_char == '0);
                        pattern_next        = PAT_W'(1);
                        overflow_next       = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_start_reg  <= '0;
            release_time_reg <= '0;
            release_seen_reg <= 1'b0;
            expect_rise_reg  <= 1'b1;
            pattern_reg      <= PAT_W'(1);
            overflow_reg     <= 1'b0;
            press_lamp_reg   <= 1'b0;
            dot_lamp_reg     <= 1'b0;
            dash_lamp_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                press_start_reg  <= press_start_next;
                release_time_reg <= release_time_next;
                release_seen_reg <= release_seen_next;
                expect_rise_reg  <= expect_rise_next;
                pattern_reg      <= pattern_next;
                overflow_reg     <= overflow_next;
                press_lamp_reg   <= press_lamp_next;
                dot_lamp_reg     <= dot_lamp_next;
                dash_lamp_reg    <= dash_lamp_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_char_valid_reg <= out_char_valid_next;
            out_char_code_reg  <= out_char_code_next;
            out_unknown_reg    <= out_unknown_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, dash_lamp_reg, dot_lamp_reg, press_lamp_reg, out_char_code_reg};
    assign m_tuser  = {out_unknown_reg, out_char_valid_reg};

    a_press_lamp_tracks_edge: assert property (@(posedge clk) disable iff (!rst_n)
        press_lamp_reg != expect_rise_reg)
        else $error("press lamp out of step with edge expectation");

    a_release_implies_idle_key: assert property (@(posedge clk) disable iff (!rst_n)
        release_seen_reg |-> expect_rise_reg)
        else $error("release pending while key is down");

    a_marker_present: assert property (@(posedge clk) disable iff (!rst_n)
        pattern_reg != '0)
        else $error("pattern lost its marker bit");

    a_idle_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[6:0] == '0 && !m_tuser[1]))
        else $error("character fields set without a character");

    a_unknown_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[1] == (m_tdata[6:0] == '0)))
        else $error("unknown flag disagrees with character code");

endmodule

`default_nettype wire
